@@ hw/rtl/qpht_pkg.sv @@
// Shared types and constants for the quadratic-probing hash table.
// Holds operation and status codes, slot tags and the controller/datapath structs.
// No dependencies.
`default_nettype none

package qpht_pkg;

  localparam int KEY_W      = 31;
  localparam int MOD_STEPS  = 2;
  localparam int MCNT_W     = $clog2(MOD_STEPS);
  localparam int SLOT_OUT_W = 4;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_SEARCH = 2'd1;
  localparam func_t FUNC_DELETE = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FOUND     = 3'd1;
  localparam status_t ST_DELETED   = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_EMPTY   = 2'd0;
  localparam tag_t TAG_USED    = 2'd1;
  localparam tag_t TAG_DELETED = 2'd2;

  typedef struct packed {
    logic    load;
    logic    mod_step;
    logic    probe_next;
    logic    wr_insert;
    logic    wr_delete;
    logic    set_result;
    logic    res_hit;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t op;
    logic  mod_last;
    logic  probe_last;
    logic  tag_empty;
    logic  tag_used;
    logic  key_match;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/qpht_ctrl.sv @@
// Controller state machine for the quadratic-probing hash table.
// Sequences home-slot reduction, the probe loop and result delivery.
// Depends on qpht_pkg.
`default_nettype none

module qpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire qpht_pkg::stat_t stat,
  output qpht_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HOME   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_code = qpht_pkg::ST_NOT_FOUND;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_RESULT;
        case (stat.op)
          qpht_pkg::FUNC_INSERT: begin
            if (!stat.tag_used) begin
              cmd.wr_insert = 1'b1;
              cmd.set_result = 1'b1;
              cmd.res_hit = 1'b1;
              cmd.res_code = qpht_pkg::ST_INSERTED;
            end else if (stat.probe_last) begin
              cmd.set_result = 1'b1;
              cmd.res_code = qpht_pkg::ST_FULL;
            end else begin
              cmd.probe_next = 1'b1;
              state_next = S_READ;
            end
          end
          qpht_pkg::FUNC_SEARCH, qpht_pkg::FUNC_DELETE: begin
            if (stat.tag_empty) begin
              cmd.set_result = 1'b1;
              cmd.res_code = qpht_pkg::ST_NOT_FOUND;
            end else if (stat.tag_used && stat.key_match) begin
              cmd.set_result = 1'b1;
              cmd.res_hit = 1'b1;
              if (stat.op == qpht_pkg::FUNC_DELETE) begin
                cmd.wr_delete = 1'b1;
                cmd.res_code = qpht_pkg::ST_DELETED;
              end else begin
                cmd.res_code = qpht_pkg::ST_FOUND;
              end
            end else if (stat.probe_last) begin
              cmd.set_result = 1'b1;
              cmd.res_code = qpht_pkg::ST_NOT_FOUND;
            end else begin
              cmd.probe_next = 1'b1;
              state_next = S_READ;
            end
          end
          default: begin
            cmd.set_result = 1'b1;
            cmd.res_code = qpht_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/qpht_dp.sv @@
// Datapath for the quadratic-probing hash table: key memory, slot tags,
// home-slot remainder unit, probe address stepping and the output register.
// Depends on qpht_pkg.
`default_nettype none

module qpht_dp #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire qpht_pkg::func_t                 func,
  input  wire logic [qpht_pkg::KEY_W-1:0]      key,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output qpht_pkg::status_t                    status,
  output logic [qpht_pkg::SLOT_OUT_W-1:0]      slot_index,
  input  wire qpht_pkg::cmd_t                  cmd,
  output qpht_pkg::stat_t                      stat
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam logic [SW:0] SIZE_W = (SW+1)'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST_PROBE = SW'(TABLE_SIZE - 1);
  localparam int RSH = qpht_pkg::KEY_W + SW;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << RSH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  qpht_pkg::func_t                   op;
  logic [qpht_pkg::KEY_W-1:0]        key_reg;
  logic [qpht_pkg::KEY_W+31:0]       prod;
  logic [SW-1:0]                     quot_low;
  logic [SW-1:0]                     quot_mul;
  logic [SW-1:0]                     home_slot;
  logic [qpht_pkg::MCNT_W-1:0]       mcnt;
  logic [SW-1:0]                     slot;
  logic [SW-1:0]                     slot_next;
  logic [SW-1:0]                     step;
  logic [SW-1:0]                     step_next;
  logic [SW-1:0]                     probe;
  logic [SW:0]                       slot_sum;
  logic [SW:0]                       step_sum;
  logic [qpht_pkg::KEY_W-1:0]        key_mem [TABLE_SIZE];
  logic [qpht_pkg::KEY_W-1:0]        rd_key;
  qpht_pkg::tag_t                    tags [TABLE_SIZE];
  qpht_pkg::status_t                 res_status;
  logic [SW-1:0]                     res_slot;
  logic [SW+qpht_pkg::SLOT_OUT_W-1:0] slot_ext;

  // Key mod TABLE_SIZE by reciprocal multiplication. The first step registers the
  // low quotient bits; the second forms the remainder from the low key bits.
  assign prod = {32'd0, key_reg} * {31'd0, RECIP};
  assign quot_mul = quot_low * SW'(TABLE_SIZE);
  assign home_slot = key_reg[SW-1:0] - quot_mul;

  // Slot of probe i+1 is slot of probe i plus (2i+1), both kept mod TABLE_SIZE.
  assign slot_sum = {1'b0, slot} + {1'b0, step};
  assign slot_next = (slot_sum >= SIZE_W) ? SW'(slot_sum - SIZE_W) : slot_sum[SW-1:0];
  assign step_sum = {1'b0, step} + (SW+1)'(2);
  assign step_next = (step_sum >= SIZE_W) ? SW'(step_sum - SIZE_W) : step_sum[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= func;
      key_reg <= key;
      mcnt <= '0;
    end
    if (cmd.mod_step) begin
      quot_low <= prod[RSH +: SW];
      mcnt <= mcnt + qpht_pkg::MCNT_W'(1);
      slot <= home_slot;
      step <= SW'(1);
      probe <= '0;
    end
    if (cmd.probe_next) begin
      slot <= slot_next;
      step <= step_next;
      probe <= probe + SW'(1);
    end
    if (cmd.set_result) begin
      res_status <= cmd.res_code;
      res_slot <= cmd.res_hit ? slot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_insert) begin
      key_mem[slot] <= key_reg;
    end
    rd_key <= key_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        tags[n] <= qpht_pkg::TAG_EMPTY;
      end
    end else if (cmd.wr_insert) begin
      tags[slot] <= qpht_pkg::TAG_USED;
    end else if (cmd.wr_delete) begin
      tags[slot] <= qpht_pkg::TAG_DELETED;
    end
  end

  assign slot_ext = {{qpht_pkg::SLOT_OUT_W{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      status <= res_status;
      slot_index <= slot_ext[qpht_pkg::SLOT_OUT_W-1:0];
    end
  end

  always_comb begin
    stat.op = op;
    stat.mod_last = (mcnt == qpht_pkg::MCNT_W'(qpht_pkg::MOD_STEPS - 1));
    stat.probe_last = (probe == LAST_PROBE);
    stat.tag_empty = (tags[slot] == qpht_pkg::TAG_EMPTY);
    stat.tag_used = (tags[slot] == qpht_pkg::TAG_USED);
    stat.key_match = (rd_key == key_reg);
    stat.out_free = !out_valid || !out_stall;
  end

  a_one_tag_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_insert && cmd.wr_delete))
    else $error("Insert and delete wrote a slot tag in the same cycle.");

  a_delete_used: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_delete |-> (tags[slot] == qpht_pkg::TAG_USED))
    else $error("Delete hit a slot that does not hold a key.");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |-> (tags[slot] != qpht_pkg::TAG_USED))
    else $error("Insert overwrote an occupied slot.");

  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("Output register loaded while holding an untaken item.");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_next |=> ({1'b0, slot} < SIZE_W))
    else $error("Probe slot left the table range.");

endmodule

`default_nettype wire

@@ hw/rtl/quadratic_probe_hash_table.sv @@
// Top level of the open-addressing hash table with quadratic probing.
// Joins the controller (qpht_ctrl) and the datapath (qpht_dp); uses qpht_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in       in         in_valid / in_stall  func, key
//   out      out        out_valid / out_stall status, slot_index
//
// An item is accepted in S_IDLE, its key is reduced to its home slot in S_HOME, each
// probe goes through the key memory's registered read port (S_READ, then S_CHECK) and
// the result is loaded into the output register; the block takes one item at a time.
// Reset empties every slot at once; the block accepts items right after reset.
// A new item is taken while the previous result still waits in the output register.
`default_nettype none

module quadratic_probe_hash_table #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire qpht_pkg::func_t               func,
  input  wire logic [qpht_pkg::KEY_W-1:0]    key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output qpht_pkg::status_t                  status,
  output logic [qpht_pkg::SLOT_OUT_W-1:0]    slot_index
);

  qpht_pkg::cmd_t  cmd;
  qpht_pkg::stat_t stat;

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .key        (key),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .slot_index (slot_index),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

@@ sim/quadratic_probe_hash_table_tb.sv @@
// Self-checking testbench for quadratic_probe_hash_table: runs directed and random
// insert/search/delete items with random idling and checks every result on the fly.
// Depends on qpht_pkg and the quadratic_probe_hash_table RTL.

module quadratic_probe_hash_table_tb;

  localparam int TABLE_SIZE = 16;
  localparam int RANDOM_ITEMS = 1330;
  localparam qpht_pkg::func_t FUNC_NONE = 2'd3;

  typedef struct packed {
    qpht_pkg::func_t                 op;
    logic [qpht_pkg::KEY_W-1:0]      k;
    qpht_pkg::status_t               st;
    logic [qpht_pkg::SLOT_OUT_W-1:0] slot;
  } answer_t;

  class hash_table_model;
    qpht_pkg::tag_t             tags[TABLE_SIZE];
    logic [qpht_pkg::KEY_W-1:0] keys[TABLE_SIZE];
    answer_t                    answers_due[$];
    int                         mismatches;

    function new();
      foreach (tags[i]) begin
        tags[i] = qpht_pkg::TAG_EMPTY;
        keys[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void apply_op(qpht_pkg::func_t op, logic [qpht_pkg::KEY_W-1:0] k);
      int unsigned home;
      int unsigned s;
      answer_t a;
      home = k % TABLE_SIZE;
      a.op = op;
      a.k = k;
      a.st = qpht_pkg::ST_NOT_FOUND;
      a.slot = '0;
      if (op == qpht_pkg::FUNC_INSERT) begin
        a.st = qpht_pkg::ST_FULL;
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
          s = (home + i * i) % TABLE_SIZE;
          if (tags[s] != qpht_pkg::TAG_USED) begin
            tags[s] = qpht_pkg::TAG_USED;
            keys[s] = k;
            a.st = qpht_pkg::ST_INSERTED;
            a.slot = s[qpht_pkg::SLOT_OUT_W-1:0];
            break;
          end
        end
      end else if (op == qpht_pkg::FUNC_SEARCH || op == qpht_pkg::FUNC_DELETE) begin
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
          s = (home + i * i) % TABLE_SIZE;
          if (tags[s] == qpht_pkg::TAG_EMPTY) break;
          if (tags[s] == qpht_pkg::TAG_USED && keys[s] == k) begin
            if (op == qpht_pkg::FUNC_DELETE) begin
              tags[s] = qpht_pkg::TAG_DELETED;
              a.st = qpht_pkg::ST_DELETED;
            end else begin
              a.st = qpht_pkg::ST_FOUND;
            end
            a.slot = s[qpht_pkg::SLOT_OUT_W-1:0];
            break;
          end
        end
      end
      answers_due.push_back(a);
    endfunction

    function void check_answer(qpht_pkg::status_t st, logic [qpht_pkg::SLOT_OUT_W-1:0] slot);
      answer_t a;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d", st, slot);
        return;
      end
      a = answers_due.pop_front();
      if (st !== a.st || slot !== a.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("func %0d key %0h: expected status %0d slot %0d, got status %0d slot %0d",
                   a.op, a.k, a.st, a.slot, st, slot);
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  qpht_pkg::func_t                 func = qpht_pkg::FUNC_INSERT;
  logic [qpht_pkg::KEY_W-1:0]      key = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  qpht_pkg::status_t               status;
  logic [qpht_pkg::SLOT_OUT_W-1:0] slot_index;

  hash_table_model tbl = new();
  bit quiet = 1'b0;
  int hold = 0;
  logic [qpht_pkg::KEY_W-1:0] key_pool[$];

  quadratic_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .key(key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .slot_index(slot_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("quadratic_probe_hash_table_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        tbl.check_answer(status, slot_index);
        hold = quiet ? 0 : $urandom_range(0, 3);
      end else if (hold > 0) begin
        hold = hold - 1;
      end
      out_stall <= (hold > 0);
    end
  end

  task automatic send_op(qpht_pkg::func_t op, logic [qpht_pkg::KEY_W-1:0] k);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    key <= k;
    do @(posedge clk); while (in_stall);
    tbl.apply_op(op, k);
  endtask

  task automatic pick_op(int unsigned phase, output qpht_pkg::func_t op,
                         output logic [qpht_pkg::KEY_W-1:0] k);
    int unsigned pick;
    int unsigned ins_pct;
    ins_pct = (phase % 2) ? 55 : 30;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) op = qpht_pkg::FUNC_INSERT;
    else if (pick < ins_pct + 30) op = qpht_pkg::FUNC_SEARCH;
    else if (pick < 95) op = qpht_pkg::FUNC_DELETE;
    else op = FUNC_NONE;
    pick = $urandom_range(0, 9);
    if (pick < 4 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (pick < 8) begin
      k = qpht_pkg::KEY_W'($urandom);
      if ($urandom_range(0, 1)) begin
        k[qpht_pkg::KEY_W-1:4] = (qpht_pkg::KEY_W-4)'($urandom_range(0, 3));
      end
      k[3:0] = 4'((phase * 5 + $urandom_range(0, 3)) % 16);
    end else begin
      k = qpht_pkg::KEY_W'($urandom);
    end
  endtask

  initial begin
    qpht_pkg::func_t op;
    logic [qpht_pkg::KEY_W-1:0] k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, collisions on home slot 0,
    // duplicates, tombstones, a full probe path and the extreme keys.
    send_op(qpht_pkg::FUNC_SEARCH, 31'd0);
    send_op(qpht_pkg::FUNC_DELETE, 31'd5);
    send_op(FUNC_NONE, 31'h7FFF_FFFF);
    send_op(qpht_pkg::FUNC_INSERT, 31'd0);
    send_op(qpht_pkg::FUNC_INSERT, 31'd16);
    send_op(qpht_pkg::FUNC_INSERT, 31'd32);
    send_op(qpht_pkg::FUNC_INSERT, 31'd0);
    send_op(qpht_pkg::FUNC_SEARCH, 31'd0);
    send_op(qpht_pkg::FUNC_DELETE, 31'd0);
    send_op(qpht_pkg::FUNC_SEARCH, 31'd0);
    send_op(qpht_pkg::FUNC_SEARCH, 31'd16);
    send_op(qpht_pkg::FUNC_INSERT, 31'd48);
    send_op(qpht_pkg::FUNC_INSERT, 31'd64);
    send_op(qpht_pkg::FUNC_SEARCH, 31'd64);
    send_op(qpht_pkg::FUNC_INSERT, 31'h7FFF_FFFF);
    send_op(qpht_pkg::FUNC_SEARCH, 31'h7FFF_FFFF);
    send_op(qpht_pkg::FUNC_DELETE, 31'h7FFF_FFFF);
    send_op(qpht_pkg::FUNC_SEARCH, 31'h7FFF_FFFF);
    send_op(FUNC_NONE, 31'd16);
    send_op(qpht_pkg::FUNC_SEARCH, 31'd16);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 100) % 3 == 2);
      pick_op(n / 100, op, k);
      if (op == qpht_pkg::FUNC_INSERT) begin
        key_pool.push_back(k);
        if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
      send_op(op, k);
    end
    in_valid <= 1'b0;

    while (tbl.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tbl.mismatches == 0) begin
      $display("quadratic_probe_hash_table_tb: clean");
    end else begin
      $display("quadratic_probe_hash_table_tb: errors");
    end
    $finish;
  end

endmodule
